@@ design/pah_pkg.sv @@
// Package for the page access histogram: field widths, limits and the
// control bundle shared by the top level and its table cells. No dependencies.
`default_nettype none

package pah_pkg;

    localparam int ADDR_W = 64;   // load address
    localparam int TAG_W  = 52;   // page number kept per entry
    localparam int CNT_W  = 32;   // hit and drop counters
    localparam int RANK_W = 6;    // read rank
    localparam int USED_W = 7;    // reported occupancy

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // broadcast from the top level to every cell in a cycle
    typedef struct packed {
        logic upd;      // a nonzero sample is applied this cycle
        logic hit_any;  // some cell already holds the page
        logic ins;      // table has room: open a slot for a new page
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ design/pah_cell.sv @@
// One table slot of the page access histogram: page tag and hit count.
// Compares against the broadcast page and takes its left neighbor's entry on insert.
// Depends on pah_pkg.
`default_nettype none

module pah_cell
    import pah_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [TAG_W-1:0] i_page,
    input  wire logic             i_used,       // slot holds a live entry
    input  wire logic             i_prev_lt,    // left neighbor sorts below the page
    input  wire logic [TAG_W-1:0] i_prev_tag,
    input  wire logic [CNT_W-1:0] i_prev_count,
    output logic                  o_lt,
    output logic                  o_eq,
    output logic [TAG_W-1:0]      o_tag,
    output logic [CNT_W-1:0]      o_count
);

    logic [TAG_W-1:0] r_tag;
    logic [CNT_W-1:0] r_count;
    logic [TAG_W-1:0] n_tag;
    logic [CNT_W-1:0] n_count;

    assign o_lt    = i_used && (r_tag < i_page);
    assign o_eq    = i_used && (r_tag == i_page);
    assign o_tag   = r_tag;
    assign o_count = r_count;

    always_comb begin
        n_tag   = r_tag;
        n_count = r_count;
        if (i_ctl.upd) begin
            if (i_ctl.hit_any) begin
                if (o_eq && (r_count != CNT_MAX)) begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (i_ctl.ins && !o_lt) begin
                if (i_prev_lt) begin
                    // first slot at or above the new page: it lands here
                    n_tag   = i_page;
                    n_count = CNT_W'(1);
                end else begin
                    // above the insert point: move up one place
                    n_tag   = i_prev_tag;
                    n_count = i_prev_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_count <= n_count;
    end

endmodule

`default_nettype wire

@@ design/page_access_histogram.sv @@
// Top level of the page access histogram: input register, chain of table
// cells, occupancy and drop counters, read selection and output register.
// Depends on pah_pkg and pah_cell.
`default_nettype none

// Per-page histogram of sampled load addresses. The table is a row of
// TABLE_ENTRIES cells kept in ascending page order (page = address >>
// PAGE_SHIFT, low 52 bits). Every cell compares the incoming page with its
// own tag in the same cycle; a matching cell bumps its saturating count,
// otherwise the first cell at or above the page takes the new page and every
// cell above it takes its left neighbor's entry.
// Samples for a new page while the table is full are dropped and counted.
// Address zero is ignored. A read request (req_type 1) returns the entry at
// the given rank plus occupancy and drop count; ranks at or above occupancy
// read as all zero with entry_valid low. Timing: an item is registered on
// acceptance and applied to the cells in the next cycle, so one item per
// cycle is accepted; a read result passes from the input register into
// the output register and sits there, and only a read blocked by a
// stalled result holds off new items. Nothing needs clearing after reset.
module page_access_histogram
    import pah_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,   // 2..64
    parameter int PAGE_SHIFT    = 12    // 6..30
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request side
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_req_type,
    input  wire logic [ADDR_W-1:0] i_load_address,
    input  wire logic [RANK_W-1:0] i_entry_rank,
    // result side
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_entry_valid,
    output logic [TAG_W-1:0]       o_page_number,
    output logic [CNT_W-1:0]       o_hit_count,
    output logic [USED_W-1:0]      o_entries_used,
    output logic [CNT_W-1:0]       o_dropped_samples
);

    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

    // input register
    logic              r_a_valid;
    logic              r_a_read;
    logic              r_a_nz;
    logic [TAG_W-1:0]  r_a_page;
    logic [RANK_W-1:0] r_a_rank;

    // counters
    logic [OCC_W-1:0]  r_occ;
    logic [CNT_W-1:0]  r_drop;

    // output register
    logic              r_out_valid;
    logic              r_out_entry_valid;
    logic [TAG_W-1:0]  r_out_page;
    logic [CNT_W-1:0]  r_out_count;
    logic [USED_W-1:0] r_out_used;
    logic [CNT_W-1:0]  r_out_drop;

    logic adv;
    logic accept;
    logic full;
    t_cell_ctl ctl;

    logic [TABLE_ENTRIES-1:0] cell_lt;
    logic [TABLE_ENTRIES-1:0] cell_eq;
    logic [TAG_W-1:0]         cell_tag   [TABLE_ENTRIES];
    logic [CNT_W-1:0]         cell_count [TABLE_ENTRIES];

    logic [TAG_W-1:0] sel_tag;
    logic [CNT_W-1:0] sel_count;
    logic             rank_ok;

    // a read may only leave stage A when the output register can take it
    assign adv     = r_a_valid && (!r_a_read || !r_out_valid || !i_stall);
    assign o_stall = r_a_valid && !adv;
    assign accept  = i_valid && !o_stall;

    assign full        = (r_occ == OCC_W'(TABLE_ENTRIES));
    assign ctl.upd     = adv && !r_a_read && r_a_nz;
    assign ctl.hit_any = |cell_eq;
    assign ctl.ins     = !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_read <= (i_req_type == REQ_READ);
            r_a_nz   <= (i_load_address != '0);
            r_a_page <= TAG_W'(i_load_address >> PAGE_SHIFT);
            r_a_rank <= i_entry_rank;
        end
    end

    // cell chain; slot 0 always has a "below" neighbor
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic             prev_lt;
        logic [TAG_W-1:0] prev_tag;
        logic [CNT_W-1:0] prev_count;

        if (g == 0) begin : g_head
            assign prev_lt    = 1'b1;
            assign prev_tag   = '0;
            assign prev_count = '0;
        end else begin : g_link
            assign prev_lt    = cell_lt[g-1];
            assign prev_tag   = cell_tag[g-1];
            assign prev_count = cell_count[g-1];
        end

        pah_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_page       (r_a_page),
            .i_used       (OCC_W'(g) < r_occ),
            .i_prev_lt    (prev_lt),
            .i_prev_tag   (prev_tag),
            .i_prev_count (prev_count),
            .o_lt         (cell_lt[g]),
            .o_eq         (cell_eq[g]),
            .o_tag        (cell_tag[g]),
            .o_count      (cell_count[g])
        );
    end

    // occupancy and drops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_drop <= '0;
        end else if (ctl.upd && !ctl.hit_any) begin
            if (full) begin
                if (r_drop != CNT_MAX) begin
                    r_drop <= r_drop + CNT_W'(1);
                end
            end else begin
                r_occ <= r_occ + OCC_W'(1);
            end
        end
    end

    // rank select: and-or over the cells
    always_comb begin
        sel_tag   = '0;
        sel_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r_a_rank == RANK_W'(i)) begin
                sel_tag   = sel_tag | cell_tag[i];
                sel_count = sel_count | cell_count[i];
            end
        end
    end

    assign rank_ok = ({1'b0, r_a_rank} < USED_W'(r_occ));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_a_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_a_read) begin
            r_out_entry_valid <= rank_ok;
            r_out_page        <= rank_ok ? sel_tag : '0;
            r_out_count       <= rank_ok ? sel_count : '0;
            r_out_used        <= USED_W'(r_occ);
            r_out_drop        <= r_drop;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_entry_valid     = r_out_entry_valid;
    assign o_page_number     = r_out_page;
    assign o_hit_count       = r_out_count;
    assign o_entries_used    = r_out_used;
    assign o_dropped_samples = r_out_drop;

endmodule

`default_nettype wire

@@ design/pah_checker.sv @@
// Port-level checks for the page access histogram, bound to the top level.
// Depends on pah_pkg and page_access_histogram.
`default_nettype none

module pah_checker
    import pah_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_stall,
    input wire logic              o_valid,
    input wire logic              o_entry_valid,
    input wire logic [TAG_W-1:0]  o_page_number,
    input wire logic [CNT_W-1:0]  o_hit_count,
    input wire logic [USED_W-1:0] o_entries_used,
    input wire logic [CNT_W-1:0]  o_dropped_samples
);

    // a stalled result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // empty rank reads as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> (o_page_number == '0) && (o_hit_count == '0))
        else $error("invalid rank with nonzero payload");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entries_used <= USED_W'(TABLE_ENTRIES))
        else $error("occupancy above table size");

    // a live entry was hit at least once
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_valid |-> o_hit_count != '0)
        else $error("live entry with zero count");

    // drops only happen once the table is full, and it never shrinks
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_dropped_samples != '0) |-> o_entries_used == USED_W'(TABLE_ENTRIES))
        else $error("drops counted with room in table");

endmodule

bind page_access_histogram pah_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_pah_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_stall           (i_stall),
    .o_valid           (o_valid),
    .o_entry_valid     (o_entry_valid),
    .o_page_number     (o_page_number),
    .o_hit_count       (o_hit_count),
    .o_entries_used    (o_entries_used),
    .o_dropped_samples (o_dropped_samples)
);

`default_nettype wire

@@ verif/tb_page_access_histogram.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for page_access_histogram: a sorted per-page hit table checked
// against an in-bench predictor on every read item. Depends on pah_pkg and the block.

module tb_page_access_histogram;
    import pah_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int PAGE_SHIFT    = 12;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int HOLD_SPAN     = 200;     // long receiver hold-off, in cycles
    localparam int DRAIN_LIMIT   = 5000;    // cycles to wait for outstanding reads
    localparam int TAIL_CYCLES   = 4;       // idle tail after the drain

    // One read item's answer, packed so a whole result compares in one step.
    typedef struct packed {
        logic              entry_valid;
        logic [TAG_W-1:0]  page_number;
        logic [CNT_W-1:0]  hit_count;
        logic [USED_W-1:0] entries_used;
        logic [CNT_W-1:0]  dropped_samples;
    } t_read_result;

    // Block inputs start at known values; reset held low from time zero.
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              i_req_type     = REQ_SAMPLE;
    logic [ADDR_W-1:0] i_load_address = '0;
    logic [RANK_W-1:0] i_entry_rank   = '0;
    logic              i_stall        = 1'b0;

    logic              o_stall;
    logic              o_valid;
    logic              o_entry_valid;
    logic [TAG_W-1:0]  o_page_number;
    logic [CNT_W-1:0]  o_hit_count;
    logic [USED_W-1:0] o_entries_used;
    logic [CNT_W-1:0]  o_dropped_samples;

    page_access_histogram #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PAGE_SHIFT   (PAGE_SHIFT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_load_address   (i_load_address),
        .i_entry_rank     (i_entry_rank),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_entry_valid    (o_entry_valid),
        .o_page_number    (o_page_number),
        .o_hit_count      (o_hit_count),
        .o_entries_used   (o_entries_used),
        .o_dropped_samples(o_dropped_samples)
    );

    always #6 i_clk = ~i_clk;

    // Predicted table: sorted page tags with hit counts, occupancy and drops.
    logic [TAG_W-1:0] tag_row  [TABLE_ENTRIES];
    logic [CNT_W-1:0] hits_row [TABLE_ENTRIES];
    int               rows_used  = 0;
    logic [CNT_W-1:0] drops_seen = '0;
    t_read_result     pending_reads[$];

    // Shared controls and tallies.
    bit gaps_on     = 1'b1;     // random idling on both sides
    int hold_serial = 0;        // bumped to ask the receiver for a hold-off
    int hold_taken  = 0;
    int hold_left   = 0;
    int errors      = 0;
    int reads_sent  = 0;
    int samples_sent = 0;
    int input_stalls = 0;
    int reads_checked = 0;

    // Apply one accepted item to the predicted table; a read queues its answer.
    function automatic void histogram_apply(logic req, logic [ADDR_W-1:0] addr,
                                            logic [RANK_W-1:0] rank);
        logic [TAG_W-1:0] page;
        int               pos;
        t_read_result     ans;
        if (req == REQ_READ) begin
            ans = '0;
            if (int'(rank) < rows_used) begin
                ans.entry_valid = 1'b1;
                ans.page_number = tag_row[rank];
                ans.hit_count   = hits_row[rank];
            end
            ans.entries_used    = USED_W'(rows_used);
            ans.dropped_samples = drops_seen;
            pending_reads.push_back(ans);
            return;
        end
        // kernel sample: address zero leaves everything alone
        if (addr == '0)
            return;
        page = TAG_W'(addr >> PAGE_SHIFT);
        pos  = 0;
        while (pos < rows_used && tag_row[pos] < page)
            pos++;
        if (pos < rows_used && tag_row[pos] == page) begin
            if (hits_row[pos] != CNT_MAX)
                hits_row[pos]++;
        end else if (rows_used >= TABLE_ENTRIES) begin
            // table full: new page lost, drop count saturates
            if (drops_seen != CNT_MAX)
                drops_seen++;
        end else begin
            for (int k = rows_used; k > pos; k--) begin
                tag_row[k]  = tag_row[k-1];
                hits_row[k] = hits_row[k-1];
            end
            tag_row[pos]  = page;
            hits_row[pos] = CNT_W'(1);
            rows_used++;
        end
    endfunction

    // Address inside a page, random offset bits.
    function automatic logic [ADDR_W-1:0] addr_in_page(logic [TAG_W-1:0] page);
        logic [ADDR_W-1:0] offs;
        offs = {$urandom, $urandom};
        return (ADDR_W'(page) << PAGE_SHIFT) | (offs & ((ADDR_W'(1) << PAGE_SHIFT) - 1));
    endfunction

    function automatic logic [TAG_W-1:0] random_page();
        return TAG_W'({$urandom, $urandom});
    endfunction

    // Present one item and hold it until accepted. Valid is only lowered
    // in idle cycles, so back-to-back items keep valid high.
    task automatic send_item(logic req, logic [ADDR_W-1:0] addr, logic [RANK_W-1:0] rank);
        while (gaps_on && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_load_address <= addr;
        i_entry_rank   <= rank;
        @(posedge i_clk);
        while (o_stall) begin
            input_stalls++;
            @(posedge i_clk);
        end
        histogram_apply(req, addr, rank);
        if (req == REQ_READ)
            reads_sent++;
        else
            samples_sent++;
    endtask

    task automatic send_sample(logic [ADDR_W-1:0] addr);
        send_item(REQ_SAMPLE, addr, RANK_W'($urandom));
    endtask

    task automatic send_read(logic [RANK_W-1:0] rank);
        send_item(REQ_READ, {$urandom, $urandom}, rank);
    endtask

    // Receiver: random stalls, plus a counted hold-off on request.
    always @(posedge i_clk) begin
        if (hold_serial != hold_taken) begin
            hold_taken = hold_serial;
            hold_left  = HOLD_SPAN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= gaps_on && ($urandom_range(99) < 13);
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_read_result got;
        t_read_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.entry_valid     = o_entry_valid;
            got.page_number     = o_page_number;
            got.hit_count       = o_hit_count;
            got.entries_used    = o_entries_used;
            got.dropped_samples = o_dropped_samples;
            if (pending_reads.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result: valid=%b page=%h hits=%h used=%0d drops=%0d",
                             $realtime, got.entry_valid, got.page_number, got.hit_count,
                             got.entries_used, got.dropped_samples);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("[%0t] mismatch on read %0d", $realtime, reads_checked);
                        $display("    expected valid=%b page=%h hits=%h used=%0d drops=%0d",
                                 want.entry_valid, want.page_number, want.hit_count,
                                 want.entries_used, want.dropped_samples);
                        $display("    actual   valid=%b page=%h hits=%h used=%0d drops=%0d",
                                 got.entry_valid, got.page_number, got.hit_count,
                                 got.entries_used, got.dropped_samples);
                    end
                end
            end
        end
    end

    // Empty-table reads, kernel samples, page zero from a nonzero address,
    // the top page, inserts at the ends and in the middle, repeat hits, and
    // reads at and past occupancy. Count saturation needs ~4e9 samples and
    // is out of reach in a run of this length.
    task automatic test_directed_edges();
        send_read(RANK_W'(0));
        send_read(RANK_W'(TABLE_ENTRIES - 1));
        send_sample('0);
        send_read(RANK_W'(0));
        send_sample({ADDR_W{1'b1}});
        send_sample(64'h1);
        send_sample(64'h1000);
        send_sample(64'h1FFF);
        send_sample(64'h8000_0000_0000_0000);
        send_sample(64'hFFF);
        send_sample('0);
        for (int r = 0; r < 5; r++)
            send_read(RANK_W'(r));
        send_read(RANK_W'(TABLE_ENTRIES - 1));
    endtask

    // Receiver holds off for a long stretch while reads and inserts keep
    // coming, so the output register fills and the input stalls.
    task automatic test_backpressure();
        hold_serial++;
        for (int n = 0; n < 40; n++) begin
            if ($urandom_range(2) == 0)
                send_sample(addr_in_page(random_page()));
            else
                send_read(RANK_W'($urandom_range(rows_used)));
        end
    endtask

    // Grow the table to capacity with inserts all over the page range,
    // including neighbors of held pages, then drop a few and read every rank.
    task automatic test_fill_to_capacity();
        logic [TAG_W-1:0] near;
        while (rows_used < TABLE_ENTRIES) begin
            case ($urandom_range(3))
                0: send_read(RANK_W'($urandom));
                1: begin
                    near = tag_row[$urandom_range(rows_used - 1)];
                    near = $urandom_range(1) ? near + 1 : near - 1;
                    send_sample(addr_in_page(near));
                end
                default: send_sample(addr_in_page(random_page()));
            endcase
        end
        for (int n = 0; n < 4; n++)
            send_sample(addr_in_page(random_page()));
        for (int r = 0; r < TABLE_ENTRIES; r++)
            send_read(RANK_W'(r));
    endtask

    // Mixed traffic: mostly reads and hits on held pages, some new pages
    // (dropped while full), kernel samples and raw addresses. A stretch in
    // the middle runs with no idling on either side.
    task automatic test_random_traffic(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            gaps_on = !(n >= count / 3 && n < count / 3 + 300);
            pick = $urandom_range(99);
            if (pick < 40)
                send_read(RANK_W'($urandom));
            else if (pick < 75 && rows_used > 0)
                send_sample(addr_in_page(tag_row[$urandom_range(rows_used - 1)]));
            else if (pick < 87)
                send_sample(addr_in_page(random_page()));
            else if (pick < 93)
                send_sample('0);
            else
                send_sample({$urandom, $urandom});
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        int waited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_backpressure();
        test_fill_to_capacity();
        test_random_traffic(RANDOM_ITEMS);

        i_valid <= 1'b0;
        waited = 0;
        while (pending_reads.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_reads.size() != 0) begin
            errors++;
            $display("%0d read results never arrived", pending_reads.size());
        end

        $display("Covered %0d samples and %0d reads (%0d checked), %0d input stall cycles.",
                 samples_sent, reads_sent, reads_checked, input_stalls);
        $display("Table ended with %0d pages and %0d dropped samples; %0d errors.",
                 rows_used, drops_seen, errors);
        if (errors == 0)
            $display("tb_page_access_histogram: clean");
        else
            $display("tb_page_access_histogram: errors");
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial begin
        #3_000_000;
        $display("tb_page_access_histogram: errors");
        $finish;
    end

endmodule
